// File: rtl/psre_pkg.sv
package psre_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [31:0] CRC_POLY  = 32'hedb88320;
    localparam logic [31:0] CRC_ONES  = 32'hffffffff;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [16:0] BLOCK_MAX = 17'd65535;

    // header sequence positions
    localparam logic [5:0] ST_IHDR_TYPE = 6'd12;
    localparam logic [5:0] ST_IDAT_TYPE = 6'd37;
    localparam logic [5:0] ST_HDR_LAST  = 6'd42;
    // trailer sequence positions
    localparam logic [4:0] FN_CRC_FIRST = 5'd4;
    localparam logic [4:0] FN_IEND_TYPE = 5'd12;
    localparam logic [4:0] FN_LAST      = 5'd19;

    typedef enum logic [1:0] {
        K_START,
        K_PIXEL,
        K_LAST,
        K_ERROR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] px;    // {red, green, blue, alpha}
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP0,
        S_PREP1,
        S_HDR,
        S_PIX,
        S_FIN,
        S_ERR
    } t_state;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) r = DIM_W'(1);
        else if (v > maxv) r = maxv;
        else r = v;
        return r;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// File: rtl/psre_fifo.sv
module psre_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  psre_pkg::t_req i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output psre_pkg::t_req o_data
);
    import psre_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: rtl/psre_front.sv
module psre_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [31:0]               i_px,
    input  logic [psre_pkg::DIM_W-1:0] i_width,
    input  logic [psre_pkg::DIM_W-1:0] i_height,
    input  logic                      i_q_full,
    output logic                      o_push,
    output psre_pkg::t_req            o_req
);
    import psre_pkg::*;

    logic                 r_open;
    logic [2*DIM_W-2:0]   r_left;   // pixels still owed by the open image
    logic [DIM_W-1:0]     w_c, h_c;
    logic [2*DIM_W-1:0]   total;

    assign w_c   = clamp_dim(i_width, DIM_W'(MAX_WIDTH));
    assign h_c   = clamp_dim(i_height, DIM_W'(MAX_HEIGHT));
    assign total = w_c * h_c;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_req.px = i_px;
        if (!i_mode) o_req.kind = K_START;
        else if (!r_open) o_req.kind = K_ERROR;
        else if (r_left == (2*DIM_W-1)'(1)) o_req.kind = K_LAST;
        else o_req.kind = K_PIXEL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
        end else if (o_push) begin
            case (o_req.kind)
                K_START: begin
                    r_open <= 1'b1;
                    r_left <= total[2*DIM_W-2:0];
                end
                K_LAST: begin
                    r_open <= 1'b0;
                    r_left <= '0;
                end
                K_PIXEL: r_left <= r_left - (2*DIM_W-1)'(1);
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/psre_back.sv
module psre_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  psre_pkg::t_req             i_q_data,
    output logic                       o_pop,
    input  logic [psre_pkg::DIM_W-1:0] i_width,
    input  logic [psre_pkg::DIM_W-1:0] i_height,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_out_byte,
    output logic                       o_last_of_run,
    output logic                       o_file_done,
    output logic                       o_sequence_error
);
    import psre_pkg::*;

    t_state           r_state, n_state;
    logic [5:0]       r_step, n_step;
    logic [31:0]      r_crc, n_crc;
    logic [15:0]      r_alo, n_alo, r_ahi, n_ahi;
    logic [11:0]      r_col, n_col;
    logic [15:0]      r_blk, n_blk;
    logic [26:0]      r_sl, n_sl;
    logic [DIM_W-1:0] r_w, n_w, r_h, n_h;
    logic [26:0]      r_s, n_s;
    logic [31:0]      r_ilen, n_ilen;
    logic [2:0]       r_p, n_p;
    logic [2:0]       r_hidx, n_hidx;
    logic             r_lastpx, n_lastpx;
    logic [31:0]      r_px, n_px;

    logic       e_valid, e_last, e_done, e_err, e_feed, e_reset;
    logic [7:0] e_byte;
    logic       adv;

    logic [31:0] crc_out;
    logic [15:0] blen;
    logic [15:0] binv;
    logic [7:0]  pay;
    logic [16:0] lo_sum, lo_mod, hi_sum, hi_mod;
    logic [10:0] q;
    logic [16:0] rm, rm_fix;
    logic [11:0] nb;
    logic [DIM_W+1:0] w4;

    assign crc_out = ~r_crc;
    assign blen    = (r_sl > 27'(BLOCK_MAX)) ? 16'hffff : r_sl[15:0];
    assign binv    = ~blen;
    assign adv     = e_valid && (!o_out_valid || i_out_ready);
    assign o_pop   = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        case (r_p)
            3'd1:    pay = r_px[31:24];
            3'd2:    pay = r_px[23:16];
            3'd3:    pay = r_px[15:8];
            3'd4:    pay = r_px[7:0];
            default: pay = 8'd0;    // row filter byte
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_data.kind)
                        K_START: n_state = S_PREP0;
                        K_ERROR: n_state = S_ERR;
                        default: n_state = S_PIX;
                    endcase
                end
            end
            S_PREP0: n_state = S_PREP1;
            S_PREP1: n_state = S_HDR;
            S_HDR:   if (adv && r_step == ST_HDR_LAST) n_state = S_IDLE;
            S_PIX: begin
                if (adv && r_blk != 16'd0 && r_p == 3'd4)
                    n_state = r_lastpx ? S_FIN : S_IDLE;
            end
            S_FIN:   if (adv && r_step[4:0] == FN_LAST) n_state = S_IDLE;
            S_ERR:   if (adv) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // emitted byte and datapath
    always_comb begin
        e_valid = 1'b0; e_byte = 8'd0; e_last = 1'b0; e_done = 1'b0;
        e_err = 1'b0; e_feed = 1'b0; e_reset = 1'b0;
        n_step = r_step; n_crc = r_crc; n_alo = r_alo; n_ahi = r_ahi;
        n_col = r_col; n_blk = r_blk; n_sl = r_sl; n_w = r_w; n_h = r_h;
        n_s = r_s; n_ilen = r_ilen; n_p = r_p; n_hidx = r_hidx;
        n_lastpx = r_lastpx; n_px = r_px;
        lo_sum = '0; lo_mod = '0; hi_sum = '0; hi_mod = '0;
        q = r_s[26:16];
        rm = {1'b0, r_s[15:0]} + 17'(q);
        rm_fix = rm;
        nb = 12'(q);
        w4 = {r_w, 2'b00} + (DIM_W+2)'(1);
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_px     = i_q_data.px;
                    n_lastpx = (i_q_data.kind == K_LAST);
                    n_step   = 6'd0;
                    n_hidx   = 3'd0;
                    n_p      = (r_col == 12'd0) ? 3'd0 : 3'd1;
                    // dimensions are latched only by a start
                    if (i_q_data.kind == K_START) begin
                        n_w = clamp_dim(i_width, DIM_W'(MAX_WIDTH));
                        n_h = clamp_dim(i_height, DIM_W'(MAX_HEIGHT));
                    end
                end
            end
            S_PREP0: n_s = 27'(w4) * 27'(r_h);
            S_PREP1: begin
                // s / 65535 rounded up: 2^16 = 65535 + 1
                if (rm >= BLOCK_MAX) begin
                    rm_fix = rm - BLOCK_MAX;
                    nb     = 12'(q) + 12'd1;
                end
                if (rm_fix != 17'd0) nb = nb + 12'd1;
                n_ilen = 32'd6 + 32'(r_s) + 32'(nb) * 32'd5;
            end
            S_HDR: begin
                e_valid = 1'b1;
                e_feed  = (r_step >= ST_IHDR_TYPE && r_step <= 6'd28) ||
                          (r_step >= ST_IDAT_TYPE);
                e_reset = (r_step == ST_IHDR_TYPE) || (r_step == ST_IDAT_TYPE);
                e_last  = (r_step == ST_HDR_LAST);
                case (r_step)
                    6'd0:  e_byte = 8'h89;
                    6'd1:  e_byte = 8'h50;
                    6'd2:  e_byte = 8'h4e;
                    6'd3:  e_byte = 8'h47;
                    6'd4:  e_byte = 8'h0d;
                    6'd5:  e_byte = 8'h0a;
                    6'd6:  e_byte = 8'h1a;
                    6'd7:  e_byte = 8'h0a;
                    6'd11: e_byte = 8'h0d;
                    6'd12: e_byte = 8'h49;
                    6'd13: e_byte = 8'h48;
                    6'd14: e_byte = 8'h44;
                    6'd15: e_byte = 8'h52;
                    6'd18: e_byte = 8'(r_w[DIM_W-1:8]);
                    6'd19: e_byte = r_w[7:0];
                    6'd22: e_byte = 8'(r_h[DIM_W-1:8]);
                    6'd23: e_byte = r_h[7:0];
                    6'd24: e_byte = 8'h08;
                    6'd25: e_byte = 8'h06;
                    6'd29: e_byte = crc_out[31:24];
                    6'd30: e_byte = crc_out[23:16];
                    6'd31: e_byte = crc_out[15:8];
                    6'd32: e_byte = crc_out[7:0];
                    6'd33: e_byte = r_ilen[31:24];
                    6'd34: e_byte = r_ilen[23:16];
                    6'd35: e_byte = r_ilen[15:8];
                    6'd36: e_byte = r_ilen[7:0];
                    6'd37: e_byte = 8'h49;
                    6'd38: e_byte = 8'h44;
                    6'd39: e_byte = 8'h41;
                    6'd40: e_byte = 8'h54;
                    6'd41: e_byte = 8'h78;
                    6'd42: e_byte = 8'h01;
                    default: e_byte = 8'h00;
                endcase
                if (adv) begin
                    n_step = r_step + 6'd1;
                    if (r_step == ST_HDR_LAST) begin
                        n_alo = 16'd1; n_ahi = 16'd0; n_col = 12'd0;
                        n_blk = 16'd0; n_sl = r_s;
                    end
                end
            end
            S_PIX: begin
                e_valid = 1'b1;
                e_feed  = 1'b1;
                if (r_blk == 16'd0) begin
                    // stored block header
                    case (r_hidx)
                        3'd0:    e_byte = (r_sl <= 27'(BLOCK_MAX)) ? 8'd1 : 8'd0;
                        3'd1:    e_byte = blen[7:0];
                        3'd2:    e_byte = blen[15:8];
                        3'd3:    e_byte = binv[7:0];
                        default: e_byte = binv[15:8];
                    endcase
                    if (adv) begin
                        if (r_hidx == 3'd4) begin
                            n_hidx = 3'd0;
                            n_blk  = blen;
                        end else begin
                            n_hidx = r_hidx + 3'd1;
                        end
                    end
                end else begin
                    e_byte = pay;
                    e_last = (r_p == 3'd4) && !r_lastpx;
                    lo_sum = {1'b0, r_alo} + 17'(pay);
                    lo_mod = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
                    hi_sum = {1'b0, r_ahi} + lo_mod;
                    hi_mod = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;
                    if (adv) begin
                        n_alo = lo_mod[15:0];
                        n_ahi = hi_mod[15:0];
                        n_blk = r_blk - 16'd1;
                        n_sl  = r_sl - 27'd1;
                        n_p   = r_p + 3'd1;
                        if (r_p == 3'd4) begin
                            n_step = 6'd0;
                            n_col  = ({1'b0, r_col} + 13'd1 >= r_w) ? 12'd0
                                                                     : r_col + 12'd1;
                        end
                    end
                end
            end
            S_FIN: begin
                e_valid = 1'b1;
                e_feed  = (r_step[4:0] < FN_CRC_FIRST) ||
                          (r_step[4:0] >= FN_IEND_TYPE && r_step[4:0] < 5'd16);
                e_reset = (r_step[4:0] == FN_IEND_TYPE);
                e_last  = (r_step[4:0] == FN_LAST);
                e_done  = e_last;
                case (r_step[4:0])
                    5'd0:  e_byte = r_ahi[15:8];
                    5'd1:  e_byte = r_ahi[7:0];
                    5'd2:  e_byte = r_alo[15:8];
                    5'd3:  e_byte = r_alo[7:0];
                    5'd4:  e_byte = crc_out[31:24];
                    5'd5:  e_byte = crc_out[23:16];
                    5'd6:  e_byte = crc_out[15:8];
                    5'd7:  e_byte = crc_out[7:0];
                    5'd12: e_byte = 8'h49;
                    5'd13: e_byte = 8'h45;
                    5'd14: e_byte = 8'h4e;
                    5'd15: e_byte = 8'h44;
                    5'd16: e_byte = crc_out[31:24];
                    5'd17: e_byte = crc_out[23:16];
                    5'd18: e_byte = crc_out[15:8];
                    5'd19: e_byte = crc_out[7:0];
                    default: e_byte = 8'h00;
                endcase
                if (adv) n_step = r_step + 6'd1;
            end
            S_ERR: begin
                e_valid = 1'b1;
                e_err   = 1'b1;
                e_last  = 1'b1;
            end
            default: ;
        endcase
        if (adv && e_feed) n_crc = crc_byte(e_reset ? CRC_ONES : r_crc, e_byte);
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step; r_w <= n_w; r_h <= n_h; r_s <= n_s; r_ilen <= n_ilen;
        r_p <= n_p; r_lastpx <= n_lastpx; r_px <= n_px;
        if (adv) begin
            o_out_byte       <= e_byte;
            o_last_of_run    <= e_last;
            o_file_done      <= e_done;
            o_sequence_error <= e_err;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_crc       <= CRC_ONES;
            r_alo       <= 16'd1;
            r_ahi       <= 16'd0;
            r_col       <= 12'd0;
            r_blk       <= 16'd0;
            r_sl        <= 27'd0;
            r_hidx      <= 3'd0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_crc   <= n_crc;
            r_alo   <= n_alo;
            r_ahi   <= n_ahi;
            r_col   <= n_col;
            r_blk   <= n_blk;
            r_sl    <= n_sl;
            r_hidx  <= n_hidx;
            if (adv) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
    end

endmodule

// File: rtl/png_stored_rgba_encoder_top.sv
// PNG encoder for RGBA8 images using stored (uncompressed) deflate blocks.
// A start request (mode 0) emits the signature, IHDR with its CRC, the IDAT
// length and type and the zlib header: 43 bytes. The request is fetched from
// the queue and the IDAT length is worked out in S_PREP0 and S_PREP1 before
// the header streams.
// A pixel request (mode 1) emits an optional filter byte, the four channel
// bytes and a 5-byte stored block header before the first payload byte and
// each time 65535 payload bytes have passed: one byte per cycle while
// the output is not stalled, through the serial CRC-32 and, for payload
// bytes, Adler-32. Each request is first fetched from the queue. The last
// pixel of the image adds 20 trailer bytes (Adler, IDAT CRC, IEND). A pixel
// with no image open gives one byte with o_sequence_error set.
// Width and height (registers 0 and 1, clamped to 1..4096) are sampled when
// a start request is taken; write them only while the block is idle.
module png_stored_rgba_encoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [psre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psre_pkg::DIM_W-1:0]    i_cfg_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic [7:0]                    i_alpha,
    // byte output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last_of_run,
    output logic                          o_file_done,
    output logic                          o_sequence_error
);
    import psre_pkg::*;

    logic [DIM_W-1:0] r_width, r_height;
    logic             q_full, q_push, q_pop, q_valid;
    t_req             q_in, q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;  // unused index, ignored
            endcase
        end
    end

    // front: takes requests, tracks open image, classifies
    psre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_px       ({i_red, i_green, i_blue, i_alpha}),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_req      (q_in)
    );

    // two-entry queue decouples front and byte sequencer
    psre_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // back: byte sequencer with CRC/Adler and output register
    psre_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_data         (q_out),
        .o_pop            (q_pop),
        .i_width          (r_width),
        .i_height         (r_height),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .o_file_done      (o_file_done),
        .o_sequence_error (o_sequence_error)
    );

endmodule

// File: verif/psre_checker.sv
module psre_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [psre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psre_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_mode,
    input  logic [7:0]                     i_red,
    input  logic [7:0]                     i_green,
    input  logic [7:0]                     i_blue,
    input  logic [7:0]                     i_alpha,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [7:0]                     i_out_byte,
    input  logic                           i_last_of_run,
    input  logic                           i_file_done,
    input  logic                           i_sequence_error,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import psre_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       err;
    } t_file_byte;

    t_file_byte file_bytes_q[$];

    logic [DIM_W-1:0] reg_width, reg_height;
    logic [DIM_W-1:0] img_width;
    logic             img_open;
    logic [31:0]      crc_acc;
    logic [15:0]      sum_lo, sum_hi;
    int               col_cnt;
    int               blk_left;
    int               strm_left;

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic done = 1'b0,
                             input logic err = 1'b0);
        t_file_byte e;
        e.data = b;
        e.last = 1'b0;
        e.done = done;
        e.err  = err;
        file_bytes_q = {file_bytes_q, e};
    endtask

    task automatic push_crc(input logic [7:0] b);
        crc_acc = crc_acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ CRC_POLY) : (crc_acc >> 1);
        push_byte(b);
    endtask

    task automatic push_word(input logic [31:0] w, input bit thru_crc);
        for (int s = 24; s >= 0; s -= 8) begin
            if (thru_crc) push_crc(w[s+:8]);
            else push_byte(w[s+:8]);
        end
    endtask

    task automatic push_chunk_type(input logic [31:0] tag);
        crc_acc = CRC_ONES;
        push_word(tag, 1'b1);
    endtask

    task automatic push_payload(input logic [7:0] b);
        int len;
        logic [15:0] inv;
        if (blk_left == 0) begin
            len = (strm_left > 65535) ? 65535 : strm_left;
            inv = ~len[15:0];
            push_crc((strm_left <= 65535) ? 8'd1 : 8'd0);
            push_crc(len[7:0]);
            push_crc(len[15:8]);
            push_crc(inv[7:0]);
            push_crc(inv[15:8]);
            blk_left = len;
        end
        push_crc(b);
        sum_lo = (32'(sum_lo) + b >= 65521) ? 16'(32'(sum_lo) + b - 65521) : sum_lo + b;
        sum_hi = (32'(sum_hi) + sum_lo >= 65521) ? 16'(32'(sum_hi) + sum_lo - 65521)
                                                 : sum_hi + sum_lo;
        blk_left--;
        strm_left--;
    endtask

    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v, input int mx);
        if (v == 0) return DIM_W'(1);
        return (v > mx) ? DIM_W'(mx) : v;
    endfunction

    task automatic predict_start();
        logic [DIM_W-1:0] h;
        int s, nb;
        logic [31:0] c;
        img_width = limit_dim(reg_width, MAX_WIDTH);
        h = limit_dim(reg_height, MAX_HEIGHT);
        s  = (4 * img_width + 1) * h;
        nb = (s + 65534) / 65535;
        push_word(32'h89504e47, 1'b0);
        push_word(32'h0d0a1a0a, 1'b0);
        push_word(32'd13, 1'b0);
        push_chunk_type("IHDR");
        push_word(32'(img_width), 1'b1);
        push_word(32'(h), 1'b1);
        push_crc(8'd8);
        push_crc(8'd6);
        push_crc(8'd0);
        push_crc(8'd0);
        push_crc(8'd0);
        c = crc_acc ^ CRC_ONES;
        push_word(c, 1'b0);
        push_word(32'(2 + s + 5 * nb + 4), 1'b0);
        push_chunk_type("IDAT");
        push_crc(8'h78);
        push_crc(8'h01);
        sum_lo    = 16'd1;
        sum_hi    = 16'd0;
        col_cnt   = 0;
        blk_left  = 0;
        strm_left = s;
        img_open  = 1'b1;
    endtask

    task automatic predict_pixel(input logic [31:0] px);
        logic [31:0] c;
        if (col_cnt == 0) push_payload(8'd0);
        for (int s = 24; s >= 0; s -= 8) push_payload(px[s+:8]);
        col_cnt++;
        if (col_cnt >= img_width) col_cnt = 0;
        if (strm_left == 0) begin
            push_word({sum_hi, sum_lo}, 1'b1);
            push_word(crc_acc ^ CRC_ONES, 1'b0);
            push_word(32'd0, 1'b0);
            push_chunk_type("IEND");
            c = crc_acc ^ CRC_ONES;
            push_byte(c[31:24]);
            push_byte(c[23:16]);
            push_byte(c[15:8]);
            push_byte(c[7:0], 1'b1);
            img_open = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_file_byte e;
        if (!i_rst_n) begin
            reg_width  = 1;
            reg_height = 1;
            img_width  = 1;
            img_open   = 1'b0;
            crc_acc    = CRC_ONES;
            sum_lo     = 16'd1;
            sum_hi     = 16'd0;
            col_cnt    = 0;
            blk_left   = 0;
            strm_left  = 0;
            o_fail_count = 0;
            file_bytes_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH) reg_width = i_cfg_data;
                else if (i_cfg_index == CFG_HEIGHT) reg_height = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (!i_mode) predict_start();
                else if (!img_open) push_byte(8'd0, 1'b0, 1'b1);
                else predict_pixel({i_red, i_green, i_blue, i_alpha});
                file_bytes_q[file_bytes_q.size()-1].last = 1'b1;
            end
            if (i_out_valid && i_out_ready) begin
                if (file_bytes_q.size() == 0) begin
                    report($sformatf("unexpected byte %02h", i_out_byte));
                end else begin
                    e = file_bytes_q.pop_front();
                    if (i_out_byte !== e.data)
                        report($sformatf("byte %02h, want %02h", i_out_byte, e.data));
                    if (i_last_of_run !== e.last)
                        report($sformatf("last_of_run %b, want %b", i_last_of_run, e.last));
                    if (i_file_done !== e.done)
                        report($sformatf("file_done %b, want %b", i_file_done, e.done));
                    if (i_sequence_error !== e.err)
                        report($sformatf("sequence_error %b, want %b",
                                         i_sequence_error, e.err));
                end
            end
        end
        o_pending = file_bytes_q.size();
    end

endmodule

// File: verif/tb_png_stored_rgba_encoder_top.sv
module tb_png_stored_rgba_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;
    import psre_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode = 1'b0;
    logic [7:0]           i_red = '0, i_green = '0, i_blue = '0, i_alpha = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_last_of_run, o_file_done, o_sequence_error;

    int  fail_count;
    int  bytes_pending;
    int  requests_sent;
    bit  quiet;        // no idling on either side in the closing stretch
    int  stall_left;

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    png_stored_rgba_encoder_top DUT (.*);

    psre_checker u_checker (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_mode,
        .i_red, .i_green, .i_blue, .i_alpha,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_out_byte(o_out_byte), .i_last_of_run(o_last_of_run),
        .i_file_done(o_file_done), .i_sequence_error(o_sequence_error),
        .o_fail_count(fail_count), .o_pending(bytes_pending)
    );

    // Output back-pressure: random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 13);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Occasional sender gap before a request.
    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // One request on the pixel channel; holds valid until accepted.
    task automatic send_req(input logic mode, input logic [31:0] px);
        maybe_gap();
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        {i_red, i_green, i_blue, i_alpha} <= px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
        // valid stays up; a gap or the caller drops it when nothing follows
    endtask

    task automatic send_pixel(input logic [31:0] px);
        send_req(1'b1, px);
    endtask

    task automatic send_start();
        send_req(1'b0, $urandom);
    endtask

    // Config writes only while idle: drain, then allow the header latency.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_idle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    initial begin
        int w, h, npix, cut;
        requests_sent = 0;
        quiet = 1'b0;
        w = 1;
        h = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pixel with no image open right after reset
        send_pixel(32'hffffffff);
        // zero width/height clamp to 1; unused indexes are ignored
        set_dims('0, '0);
        write_reg(CFG_IDX_W'(2), '1);
        write_reg(CFG_IDX_W'(3), '1);
        send_start();
        send_pixel(32'h00000000);        // completes the 1x1 image
        send_pixel(32'h12345678);        // image closed again: error
        // oversize clamps to the maximum; image abandoned by a new start
        set_dims('1, '1);
        send_start();
        send_pixel(32'hffffffff);
        send_pixel(32'h00ff00ff);
        // config written mid-image; the next start abandons the open image
        set_dims(DIM_W'(MAX_WIDTH), DIM_W'(MAX_HEIGHT));
        send_start();
        send_pixel(32'hff00ff00);
        set_dims(DIM_W'(2), DIM_W'(2));
        send_start();
        repeat (4) send_pixel($urandom);
        send_start();
        send_pixel(32'haa55aa55);
        send_start();                    // start while open
        repeat (4) send_pixel($urandom);
        send_pixel(32'h55aa55aa);        // error after completion

        // Random images: mostly complete, some cut short, some stray pixels
        while (requests_sent < 460) begin
            if (requests_sent > 400) quiet = 1'b1;
            // closing stretch keeps the last size so requests run back to back
            if (!quiet) begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 4);
                set_dims(DIM_W'(w), DIM_W'(h));
            end
            send_start();
            npix = w * h;
            cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, npix - 1) : npix;
            for (int i = 0; i < cut; i++) send_pixel($urandom);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 2)) send_pixel($urandom);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && bytes_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/psre_pkg.sv
rtl/psre_fifo.sv
rtl/psre_front.sv
rtl/psre_back.sv
rtl/png_stored_rgba_encoder_top.sv
verif/psre_checker.sv
verif/tb_png_stored_rgba_encoder_top.sv
